>>> rtl/linear_probe_hash_table_assert.svh
// assertion macros used by the hash table back end
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, clocked on clock and disabled in reset
`define LPHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock and disabled in reset
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
// shared constants, types and hash power table for the hash table
package lpht_pkg;

   localparam int Depth     = 1024;
   localparam int AddrW     = $clog2(Depth);
   localparam int SizeW     = 11;
   localparam int KeyDigits = 11;
   localparam int KeyW      = 4 * KeyDigits;
   localparam int PayW      = 32;
   localparam int FracW     = 40;
   localparam int FuncW     = 2;
   localparam int StatW     = 3;
   localparam int TotalW    = 32;
   localparam int DigW      = $clog2(KeyDigits);

   localparam logic [FracW-1:0] GoldenQ40 = 40'd679535556991;

   localparam logic [FuncW-1:0] FuncInsert = 2'd0;
   localparam logic [FuncW-1:0] FuncLookup = 2'd1;
   localparam logic [FuncW-1:0] FuncDelete = 2'd2;

   localparam logic [StatW-1:0] StatInserted   = 3'd0;
   localparam logic [StatW-1:0] StatFull       = 3'd1;
   localparam logic [StatW-1:0] StatFound      = 3'd2;
   localparam logic [StatW-1:0] StatNotFound   = 3'd3;
   localparam logic [StatW-1:0] StatDeleted    = 3'd4;
   localparam logic [StatW-1:0] StatDeleteMiss = 3'd5;

   typedef logic [KeyDigits-1:0][FracW-1:0] pow_tab_type;

   typedef struct packed {
      logic [FuncW-1:0] func;
      logic [KeyW-1:0]  key;
      logic [PayW-1:0]  payload;
      logic [SizeW-1:0] slots;
      logic [AddrW-1:0] home;
   } job_type;

   typedef struct packed {
      logic            valid;
      logic [KeyW-1:0] key;
      logic [PayW-1:0] payload;
   } slot_type;

   // powers of the golden ratio modulo one: +/- fib(k) * A
   function automatic pow_tab_type make_pow_tab();
      pow_tab_type      t;
      logic [FracW-1:0] fp;
      logic [FracW-1:0] fc;
      logic [FracW-1:0] fn;
      logic [FracW-1:0] pr;
      fp = '0;
      fc = 40'd1;
      for (int k = 1; k <= KeyDigits; k++) begin
         pr = fc * GoldenQ40;
         t[k-1] = ((k & 1) == 1) ? pr : (~pr + 40'd1);
         fn = fp + fc;
         fp = fc;
         fc = fn;
      end
      return t;
   endfunction

   localparam pow_tab_type PowTab = make_pow_tab();

endpackage

>>> rtl/lpht_front.sv
// front end: takes requests, hashes the key one digit a cycle, scales to home slot
module lpht_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic [lpht_pkg::SizeW-1:0]  slot_count,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lpht_pkg::FuncW-1:0]  req_func,
   input  logic [lpht_pkg::KeyW-1:0]   req_key_digits,
   input  logic [lpht_pkg::PayW-1:0]   req_payload,
   output logic                        push_valid,
   input  logic                        push_ready,
   output lpht_pkg::job_type           push_job
);

   typedef enum logic [3:0] {
      FS_IDLE  = 4'b0001,
      FS_HASH  = 4'b0010,
      FS_SCALE = 4'b0100,
      FS_PUSH  = 4'b1000
   } fstate_type;

   fstate_type                       state_ff, state_in;
   logic [lpht_pkg::FuncW-1:0]       func_ff, func_in;
   logic [lpht_pkg::KeyW-1:0]        key_ff, key_in;
   logic [lpht_pkg::KeyW-1:0]        shift_ff, shift_in;
   logic [lpht_pkg::PayW-1:0]        pay_ff, pay_in;
   logic [lpht_pkg::SizeW-1:0]       slots_ff, slots_in;
   logic [lpht_pkg::FracW-1:0]       acc_ff, acc_in;
   logic [lpht_pkg::DigW-1:0]        digit_ff, digit_in;
   logic [lpht_pkg::AddrW-1:0]       home_ff, home_in;
   logic [lpht_pkg::SizeW-1:0]       slots_clamped;
   logic [7:0]                       code;
   logic [lpht_pkg::FracW-1:0]       term;
   logic [lpht_pkg::SizeW+lpht_pkg::FracW-1:0] scaled;

   assign req_ready  = (state_ff == FS_IDLE) && enable;
   assign push_valid = (state_ff == FS_PUSH);
   assign push_job   = '{func: func_ff, key: key_ff, payload: pay_ff,
                         slots: slots_ff, home: home_ff};

   always_comb begin
      if (slot_count == '0) begin
         slots_clamped = lpht_pkg::SizeW'(1);
      end else if (slot_count > lpht_pkg::SizeW'(lpht_pkg::Depth)) begin
         slots_clamped = lpht_pkg::SizeW'(lpht_pkg::Depth);
      end else begin
         slots_clamped = slot_count;
      end
   end

   assign code   = {4'h3, shift_ff[lpht_pkg::KeyW-1 -: 4]};
   assign term   = lpht_pkg::FracW'(code * lpht_pkg::PowTab[digit_ff]);
   assign scaled = slots_ff * acc_ff;

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      key_in   = key_ff;
      shift_in = shift_ff;
      pay_in   = pay_ff;
      slots_in = slots_ff;
      acc_in   = acc_ff;
      digit_in = digit_ff;
      home_in  = home_ff;
      case (state_ff)
         FS_IDLE: begin
            if (req_valid && req_ready) begin
               func_in  = req_func;
               key_in   = req_key_digits;
               shift_in = req_key_digits;
               pay_in   = req_payload;
               slots_in = slots_clamped;
               acc_in   = '0;
               digit_in = '0;
               state_in = FS_HASH;
            end
         end
         FS_HASH: begin
            acc_in   = acc_ff + term;
            shift_in = {shift_ff[lpht_pkg::KeyW-5:0], 4'h0};
            digit_in = digit_ff + lpht_pkg::DigW'(1);
            if (digit_ff == lpht_pkg::DigW'(lpht_pkg::KeyDigits - 1)) begin
               state_in = FS_SCALE;
            end
         end
         FS_SCALE: begin
            home_in  = scaled[lpht_pkg::FracW +: lpht_pkg::AddrW];
            state_in = FS_PUSH;
         end
         FS_PUSH: begin
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff  <= func_in;
      key_ff   <= key_in;
      shift_ff <= shift_in;
      pay_ff   <= pay_in;
      slots_ff <= slots_in;
      acc_ff   <= acc_in;
      digit_ff <= digit_in;
      home_ff  <= home_in;
   end

endmodule

>>> rtl/lpht_queue.sv
// two-entry job queue between front and back
module lpht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lpht_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output lpht_pkg::job_type pop_job
);

   lpht_pkg::job_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/lpht_back.sv
// back end: slot memory, clearing pass, probe engine and result register
`include "linear_probe_hash_table_assert.svh"

module lpht_back (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         clear_done,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  lpht_pkg::job_type            pop_job,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lpht_pkg::StatW-1:0]   rsp_status,
   output logic [lpht_pkg::AddrW-1:0]   rsp_slot_index,
   output logic [lpht_pkg::PayW-1:0]    rsp_found_payload,
   output logic [lpht_pkg::TotalW-1:0]  rsp_collisions
);

   typedef enum logic [3:0] {
      BS_CLEAR = 4'b0001,
      BS_IDLE  = 4'b0010,
      BS_PROBE = 4'b0100,
      BS_RESP  = 4'b1000
   } bstate_type;

   lpht_pkg::slot_type               mem [lpht_pkg::Depth];
   lpht_pkg::slot_type               rd_data_ff;
   logic [lpht_pkg::AddrW-1:0]       rd_addr;
   logic                             wr_en;
   logic [lpht_pkg::AddrW-1:0]       wr_addr;
   lpht_pkg::slot_type               wr_data;

   bstate_type                       state_ff, state_in;
   lpht_pkg::job_type                job_ff, job_in;
   logic [lpht_pkg::AddrW-1:0]       clr_addr_ff, clr_addr_in;
   logic [lpht_pkg::AddrW-1:0]       issue_addr_ff, issue_addr_in;
   logic [lpht_pkg::SizeW-1:0]       issue_k_ff, issue_k_in;
   logic                             eval_valid_ff, eval_valid_in;
   logic [lpht_pkg::AddrW-1:0]       eval_addr_ff, eval_addr_in;
   logic [lpht_pkg::SizeW-1:0]       eval_k_ff, eval_k_in;
   logic [lpht_pkg::SizeW-1:0]       coll_ff, coll_in;
   logic [lpht_pkg::TotalW-1:0]      total_ff, total_in;
   logic [lpht_pkg::StatW-1:0]       res_status_ff, res_status_in;
   logic [lpht_pkg::AddrW-1:0]       res_slot_ff, res_slot_in;
   logic [lpht_pkg::PayW-1:0]        res_pay_ff, res_pay_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::StatW-1:0]       rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::AddrW-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [lpht_pkg::PayW-1:0]        rsp_pay_ff, rsp_pay_in;
   logic [lpht_pkg::TotalW-1:0]      rsp_coll_ff, rsp_coll_in;

   logic                             issue, finish, hit, last, wrap;
   logic [lpht_pkg::SizeW-1:0]       issue_next;
   logic [lpht_pkg::SizeW-1:0]       coll_step;
   logic [lpht_pkg::SizeW-1:0]       coll_add;
   logic [lpht_pkg::TotalW:0]        total_sum;

   assign clear_done        = (state_ff != BS_CLEAR);
   assign pop_ready         = (state_ff == BS_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_collisions    = rsp_coll_ff;

   assign rd_addr    = issue_addr_ff;
   assign issue_next = {1'b0, issue_addr_ff} + lpht_pkg::SizeW'(1);
   assign issue      = (state_ff == BS_PROBE) && (issue_k_ff < job_ff.slots);
   assign hit        = rd_data_ff.valid && (rd_data_ff.key == job_ff.key);
   assign last       = (eval_k_ff == job_ff.slots - lpht_pkg::SizeW'(1));
   assign wrap       = ({1'b0, eval_addr_ff} + lpht_pkg::SizeW'(1)) == job_ff.slots;
   assign coll_step  = coll_ff + lpht_pkg::SizeW'(1) + {{(lpht_pkg::SizeW-1){1'b0}}, wrap};
   assign total_sum  = {1'b0, total_ff} + {{(lpht_pkg::TotalW+1-lpht_pkg::SizeW){1'b0}},
                                           coll_add};

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      clr_addr_in   = clr_addr_ff;
      issue_addr_in = issue_addr_ff;
      issue_k_in    = issue_k_ff;
      eval_valid_in = 1'b0;
      eval_addr_in  = eval_addr_ff;
      eval_k_in     = eval_k_ff;
      coll_in       = coll_ff;
      coll_add      = '0;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_pay_in    = res_pay_ff;
      wr_en         = 1'b0;
      wr_addr       = eval_addr_ff;
      wr_data       = rd_data_ff;
      finish        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_coll_in   = rsp_coll_ff;
      case (state_ff)
         BS_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + lpht_pkg::AddrW'(1);
            if (clr_addr_ff == lpht_pkg::AddrW'(lpht_pkg::Depth - 1)) begin
               state_in = BS_IDLE;
            end
         end
         BS_IDLE: begin
            if (pop_valid) begin
               job_in        = pop_job;
               issue_addr_in = pop_job.home;
               issue_k_in    = '0;
               coll_in       = '0;
               state_in      = BS_PROBE;
            end
         end
         BS_PROBE: begin
            if (eval_valid_ff) begin
               res_slot_in = '0;
               res_pay_in  = '0;
               if (job_ff.func == lpht_pkg::FuncInsert) begin
                  if (!rd_data_ff.valid) begin
                     finish        = 1'b1;
                     wr_en         = 1'b1;
                     wr_data       = '{valid: 1'b1, key: job_ff.key, payload: job_ff.payload};
                     res_status_in = lpht_pkg::StatInserted;
                     res_slot_in   = eval_addr_ff;
                     coll_add      = coll_ff;
                  end else begin
                     coll_in = coll_step;
                     if (last) begin
                        finish        = 1'b1;
                        res_status_in = lpht_pkg::StatFull;
                        coll_add      = coll_step;
                     end
                  end
                  if (finish) begin
                     total_in = total_sum[lpht_pkg::TotalW] ? '1
                                : total_sum[lpht_pkg::TotalW-1:0];
                  end
               end else if (job_ff.func == lpht_pkg::FuncDelete) begin
                  if (hit) begin
                     finish        = 1'b1;
                     wr_en         = 1'b1;
                     wr_data.valid = 1'b0;
                     res_status_in = lpht_pkg::StatDeleted;
                     res_slot_in   = eval_addr_ff;
                  end else if (last) begin
                     finish        = 1'b1;
                     res_status_in = lpht_pkg::StatDeleteMiss;
                  end
               end else begin
                  if (hit) begin
                     finish        = 1'b1;
                     res_status_in = lpht_pkg::StatFound;
                     res_slot_in   = eval_addr_ff;
                     res_pay_in    = rd_data_ff.payload;
                  end else if (last) begin
                     finish        = 1'b1;
                     res_status_in = lpht_pkg::StatNotFound;
                  end
               end
            end
            if (issue && !finish) begin
               eval_valid_in = 1'b1;
               eval_addr_in  = issue_addr_ff;
               eval_k_in     = issue_k_ff;
               issue_k_in    = issue_k_ff + lpht_pkg::SizeW'(1);
               issue_addr_in = (issue_next == job_ff.slots) ? '0 : issue_next[lpht_pkg::AddrW-1:0];
            end
            if (finish) begin
               state_in = BS_RESP;
            end
         end
         BS_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_coll_in   = total_ff;
               state_in      = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BS_CLEAR;
         clr_addr_ff   <= '0;
         eval_valid_ff <= 1'b0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         eval_valid_ff <= eval_valid_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      job_ff        <= job_in;
      issue_addr_ff <= issue_addr_in;
      issue_k_ff    <= issue_k_in;
      eval_addr_ff  <= eval_addr_in;
      eval_k_ff     <= eval_k_in;
      coll_ff       <= coll_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_coll_ff   <= rsp_coll_in;
   end

   `LPHT_ASSERT_NOW(a_probe_in_range, eval_valid_ff, eval_k_ff < job_ff.slots, "probe beyond ring")
   `LPHT_ASSERT_NEXT(a_probe_write_ends, wr_en && (state_ff == BS_PROBE), state_ff == BS_RESP, "probe write without finish")
   `LPHT_ASSERT_NEXT(a_resp_loads, (state_ff == BS_RESP) && !rsp_valid_ff, rsp_valid_ff && (state_ff == BS_IDLE), "result not loaded")
   `LPHT_ASSERT_NOW(a_clear_quiet, state_ff == BS_CLEAR, !rsp_valid_ff && !eval_valid_ff, "activity during clearing")

endmodule

>>> rtl/linear_probe_hash_table.sv
// top level: slot count register, front hash stage, job queue and probe back end
//
//   channel   direction   handshake                      payload
//   req       in          req_valid / req_ready          req_func, req_key_digits, req_payload
//   rsp       out         rsp_valid / rsp_ready          rsp_status, rsp_slot_index,
//                                                        rsp_found_payload, rsp_collisions
//   csr       in          csr_write_enable (no wait)     csr_write_data (slot count)
//
// after reset a clearing pass walks all 1024 slots with req_ready low
// front: 11 digit steps of the hash, scale, queue transfer; then it takes the next request
// back: probes at most n slots, n slots in use, one slot read a cycle from the memory port
// a two-entry queue and the rsp output register let front and back stall independently
module linear_probe_hash_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [lpht_pkg::SizeW-1:0]   csr_write_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lpht_pkg::FuncW-1:0]   req_func,
   input  logic [lpht_pkg::KeyW-1:0]    req_key_digits,
   input  logic [lpht_pkg::PayW-1:0]    req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lpht_pkg::StatW-1:0]   rsp_status,
   output logic [lpht_pkg::AddrW-1:0]   rsp_slot_index,
   output logic [lpht_pkg::PayW-1:0]    rsp_found_payload,
   output logic [lpht_pkg::TotalW-1:0]  rsp_collisions
);

   logic [lpht_pkg::SizeW-1:0] slot_count_ff, slot_count_in;
   logic                       clear_done;
   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   lpht_pkg::job_type          push_job, pop_job;

   assign slot_count_in = csr_write_enable ? csr_write_data : slot_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= lpht_pkg::SizeW'(16);
      end else begin
         slot_count_ff <= slot_count_in;
      end
   end

   lpht_front u_front (
      .clock          (clock),
      .reset          (reset),
      .enable         (clear_done),
      .slot_count     (slot_count_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_key_digits (req_key_digits),
      .req_payload    (req_payload),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_job       (push_job)
   );

   lpht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   lpht_back u_back (
      .clock             (clock),
      .reset             (reset),
      .clear_done        (clear_done),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_job           (pop_job),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_found_payload (rsp_found_payload),
      .rsp_collisions    (rsp_collisions)
   );

endmodule

>>> verif/linear_probe_hash_table_test.sv
// self-checking testbench for the linear probing hash table with its own slot predictor
module linear_probe_hash_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lpht_pkg::FuncW-1:0] FuncSpare = 2'd3;

   typedef struct {
      logic [lpht_pkg::StatW-1:0]  status;
      logic [lpht_pkg::AddrW-1:0]  slot;
      logic [lpht_pkg::PayW-1:0]   found;
      logic [lpht_pkg::TotalW-1:0] total;
   } hash_result_type;

   class hash_table_scoreboard;
      bit                           slot_used[lpht_pkg::Depth];
      logic [lpht_pkg::KeyW-1:0]    slot_keys[lpht_pkg::Depth];
      logic [lpht_pkg::PayW-1:0]    slot_words[lpht_pkg::Depth];
      bit [lpht_pkg::TotalW-1:0]    coll_total;
      bit [lpht_pkg::SizeW-1:0]     size_reg;
      bit [lpht_pkg::FracW-1:0]     gold_pow[1:lpht_pkg::KeyDigits];
      hash_result_type              due_q[$];
      int                           errors;

      function new();
         longint unsigned             fp, fc, fn;
         bit [lpht_pkg::FracW-1:0]    p;
         fp = 0;
         fc = 1;
         for (int k = 1; k <= lpht_pkg::KeyDigits; k++) begin
            p = lpht_pkg::FracW'(fc * longint'(lpht_pkg::GoldenQ40));
            gold_pow[k] = (k % 2 == 1) ? p : lpht_pkg::FracW'(0 - p);
            fn = fp + fc;
            fp = fc;
            fc = fn;
         end
         size_reg = 16;
         coll_total = 0;
         errors = 0;
      endfunction

      function int unsigned slots_in_use();
         if (size_reg == 0) return 1;
         if (size_reg > lpht_pkg::Depth) return lpht_pkg::Depth;
         return size_reg;
      endfunction

      function int unsigned home_of(logic [lpht_pkg::KeyW-1:0] key, int unsigned n);
         bit [lpht_pkg::FracW-1:0] acc;
         bit [lpht_pkg::FracW-1:0] term;
         bit [51:0]                prod;
         acc = 0;
         for (int i = 0; i < lpht_pkg::KeyDigits; i++) begin
            term = lpht_pkg::FracW'(8'h30 + key[4*(lpht_pkg::KeyDigits-1-i) +: 4])
                   * gold_pow[i+1];
            acc += term;
         end
         prod = 52'(n) * 52'(acc);
         return int'(prod >> lpht_pkg::FracW);
      endfunction

      function int find_key(logic [lpht_pkg::KeyW-1:0] key, int unsigned n, int unsigned h);
         int unsigned s;
         for (int unsigned k = 0; k < n; k++) begin
            s = (h + k >= n) ? h + k - n : h + k;
            if (slot_used[s] && slot_keys[s] == key) return s;
         end
         return -1;
      endfunction

      function void note_request(logic [lpht_pkg::FuncW-1:0] func,
                                 logic [lpht_pkg::KeyW-1:0] key,
                                 logic [lpht_pkg::PayW-1:0] word);
         hash_result_type r;
         int unsigned     n, h, s, coll;
         int              at;
         bit              placed;
         longint unsigned t;
         n = slots_in_use();
         h = home_of(key, n);
         r.slot = '0;
         r.found = '0;
         if (func == lpht_pkg::FuncInsert) begin
            coll = 0;
            placed = 0;
            for (int unsigned k = 0; k < n; k++) begin
               s = (h + k >= n) ? h + k - n : h + k;
               if (!slot_used[s]) begin
                  slot_used[s] = 1;
                  slot_keys[s] = key;
                  slot_words[s] = word;
                  r.slot = lpht_pkg::AddrW'(s);
                  placed = 1;
                  break;
               end
               coll++;
               if (h + k + 1 == n) coll++;
            end
            if (!placed) coll = n + 1;
            t = longint'(coll_total) + coll;
            coll_total = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lpht_pkg::TotalW'(t);
            r.status = placed ? lpht_pkg::StatInserted : lpht_pkg::StatFull;
         end else if (func == lpht_pkg::FuncDelete) begin
            at = find_key(key, n, h);
            if (at >= 0) begin
               slot_used[at] = 0;
               r.slot = lpht_pkg::AddrW'(at);
               r.status = lpht_pkg::StatDeleted;
            end else begin
               r.status = lpht_pkg::StatDeleteMiss;
            end
         end else begin
            at = find_key(key, n, h);
            if (at >= 0) begin
               r.slot = lpht_pkg::AddrW'(at);
               r.found = slot_words[at];
               r.status = lpht_pkg::StatFound;
            end else begin
               r.status = lpht_pkg::StatNotFound;
            end
         end
         r.total = coll_total;
         due_q.push_back(r);
      endfunction

      function void compare(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t mismatch %s expected %h actual %h", $realtime, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(hash_result_type got);
         hash_result_type want;
         if (due_q.size() == 0) begin
            $display("%0t unexpected result status %h slot %h", $realtime, got.status,
                     got.slot);
            errors++;
            return;
         end
         want = due_q.pop_front();
         compare("status", want.status, got.status);
         compare("slot_index", want.slot, got.slot);
         compare("found_payload", want.found, got.found);
         compare("collisions", want.total, got.total);
      endfunction
   endclass

   logic                        clock = 0;
   logic                        reset = 1;
   logic                        csr_write_enable = 0;
   logic [lpht_pkg::SizeW-1:0]  csr_write_data = '0;
   logic                        req_valid = 0;
   logic                        req_ready;
   logic [lpht_pkg::FuncW-1:0]  req_func = '0;
   logic [lpht_pkg::KeyW-1:0]   req_key_digits = '0;
   logic [lpht_pkg::PayW-1:0]   req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 0;
   logic [lpht_pkg::StatW-1:0]  rsp_status;
   logic [lpht_pkg::AddrW-1:0]  rsp_slot_index;
   logic [lpht_pkg::PayW-1:0]   rsp_found_payload;
   logic [lpht_pkg::TotalW-1:0] rsp_collisions;

   hash_table_scoreboard        table_sb = new();
   bit                          hold_rsp = 0;
   logic [lpht_pkg::KeyW-1:0]   key_pool[$];

   linear_probe_hash_table dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         table_sb.check_response('{rsp_status, rsp_slot_index, rsp_found_payload,
                                   rsp_collisions});
   end

   initial begin
      int r;
      forever begin
         r = $urandom_range(0, 99);
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (r < 50) begin
            rsp_ready <= 1;
            @(posedge clock);
         end else if (r < 80) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (r < 95) begin
            rsp_ready <= 1;
            repeat (30) @(posedge clock);
         end else begin
            rsp_ready <= 0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end
      end
   end

   function automatic int unsigned pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [lpht_pkg::KeyW-1:0] decimal_key();
      logic [lpht_pkg::KeyW-1:0] k;
      for (int i = 0; i < lpht_pkg::KeyDigits; i++) k[4*i +: 4] = 4'($urandom_range(0, 9));
      return k;
   endfunction

   function automatic logic [lpht_pkg::KeyW-1:0] raw_key();
      return {12'($urandom), 32'($urandom)};
   endfunction

   task automatic send_item(logic [lpht_pkg::FuncW-1:0] func,
                            logic [lpht_pkg::KeyW-1:0] key,
                            logic [lpht_pkg::PayW-1:0] word);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_key_digits <= key;
      req_payload <= word;
      do @(posedge clock); while (!req_ready);
      table_sb.note_request(func, key, word);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (table_sb.due_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_size(logic [lpht_pkg::SizeW-1:0] value);
      csr_write_enable <= 1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 0;
      table_sb.size_reg = value;
      @(posedge clock);
   endtask

   task automatic run_phase(logic [lpht_pkg::SizeW-1:0] size, int count, int phase);
      logic [lpht_pkg::FuncW-1:0] func;
      logic [lpht_pkg::KeyW-1:0]  key;
      int                         r, pool_n;
      write_size(size);
      key_pool.delete();
      pool_n = $urandom_range(2, 12);
      for (int i = 0; i < pool_n; i++)
         key_pool.push_back(($urandom_range(0, 4) == 0) ? raw_key() : decimal_key());
      for (int i = 0; i < count; i++) begin
         if (phase == 1 && i == 10) hold_rsp = 1;
         if (phase == 2 && i == 20) drain();
         r = $urandom_range(0, 99);
         func = (r < 45) ? lpht_pkg::FuncInsert : (r < 75) ? lpht_pkg::FuncLookup
                : (r < 95) ? lpht_pkg::FuncDelete : FuncSpare;
         key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_n - 1)]
               : raw_key();
         send_item(func, key, $urandom);
      end
      drain();
   endtask

   initial begin
      logic [lpht_pkg::SizeW-1:0] sizes[13] = '{16, 4, 1, 0, 2, 33, 8, 1024, 5, 2047, 12, 3,
                                                20};
      logic [lpht_pkg::KeyW-1:0]  k0, k1;
      repeat (6) @(posedge clock);
      reset <= 0;
      k0 = decimal_key();
      k1 = decimal_key();
      // default size, field extremes and every operation
      send_item(lpht_pkg::FuncInsert, '0, '0);
      send_item(lpht_pkg::FuncInsert, '1, '1);
      send_item(lpht_pkg::FuncLookup, '0, '0);
      send_item(lpht_pkg::FuncLookup, '1, '0);
      send_item(lpht_pkg::FuncInsert, k0, 32'h1234_5678);
      send_item(lpht_pkg::FuncInsert, k0, 32'h8765_4321);
      send_item(lpht_pkg::FuncLookup, k0, '0);
      send_item(FuncSpare, k0, '0);
      send_item(lpht_pkg::FuncDelete, k0, '0);
      send_item(lpht_pkg::FuncLookup, k0, '0);
      send_item(lpht_pkg::FuncDelete, k0, '0);
      send_item(lpht_pkg::FuncDelete, k0, '0);
      send_item(lpht_pkg::FuncLookup, k1, '0);
      send_item(lpht_pkg::FuncDelete, '1, '0);
      drain();
      // one slot: full table and wrap
      write_size(1);
      send_item(lpht_pkg::FuncInsert, k1, 32'hA5A5_A5A5);
      send_item(lpht_pkg::FuncInsert, k0, 32'h5A5A_5A5A);
      send_item(lpht_pkg::FuncLookup, k1, '0);
      send_item(lpht_pkg::FuncDelete, k1, '0);
      send_item(lpht_pkg::FuncInsert, k0, '1);
      drain();
      // zero acts as one, above depth acts as depth
      write_size(0);
      send_item(lpht_pkg::FuncInsert, k1, 32'h0F0F_0F0F);
      send_item(lpht_pkg::FuncLookup, k0, '0);
      drain();
      write_size(11'd2047);
      send_item(lpht_pkg::FuncInsert, '1, 32'hFFFF_0000);
      send_item(lpht_pkg::FuncLookup, '1, '0);
      send_item(lpht_pkg::FuncDelete, '0, '0);
      drain();
      for (int p = 0; p < 13; p++)
         run_phase(sizes[p], (sizes[p] > 100) ? 25 : 45, p);
      repeat (20) @(posedge clock);
      if (table_sb.errors == 0 && table_sb.due_q.size() == 0) begin
         $display("PASS linear_probe_hash_table");
      end else begin
         $display("FAIL linear_probe_hash_table");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL linear_probe_hash_table");
      $finish;
   end
endmodule

>>> linear_probe_hash_table.f
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_front.sv
rtl/lpht_queue.sv
rtl/lpht_back.sv
rtl/linear_probe_hash_table.sv
verif/linear_probe_hash_table_test.sv
